FILE: sv/vgu_pkg.sv
// ----------------------------------------------------------------------------
// vgu_pkg: shared types, widths and helpers for the 3d vector unit
// fixed point format, opcodes, status codes and the saturating pack
// ----------------------------------------------------------------------------
package vgu_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;

    // operands carry one extra bit so that a difference of two components fits
    localparam int OPD_W  = COMP_WIDTH + 1;
    localparam int PROD_W = 2 * OPD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    // a normalized component never exceeds one, so the quotient is this wide
    localparam int QUO_W  = FRAC_BITS + 1;

    typedef enum logic [OP_W-1:0] {
        OP_DOT   = 3'd0,
        OP_CROSS = 3'd1,
        OP_LEN   = 3'd2,
        OP_DIST  = 3'd3,
        OP_NORM  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic                  sat;
        logic [COMP_WIDTH-1:0] val;
    } packed_t;

    typedef struct packed {
        logic                       valid;
        logic [OP_W-1:0]            op;
        logic                       sat;
        logic [2:0][COMP_WIDTH-1:0] vec;
        logic [COMP_WIDTH-1:0]      scalar;
        logic [2:0][COMP_WIDTH-1:0] amag;
        logic [2:0]                 aneg;
        logic [COMP_WIDTH-1:0]      den;
        logic                       zero;
    } side_t;

    typedef struct packed {
        logic [COMP_WIDTH-1:0] rx;
        logic [COMP_WIDTH-1:0] ry;
        logic [COMP_WIDTH-1:0] rz;
        logic [COMP_WIDTH-1:0] scalar;
        logic [ST_W-1:0]       status;
    } result_t;

    // magnitude and sign to a saturated two's complement component
    function automatic packed_t sat_pack(input logic [SUM_W-1:0] mag, input logic neg);
        packed_t          r;
        logic [SUM_W-1:0] lim;
        lim = SUM_W'(1) << (COMP_WIDTH - 1);
        if (mag > lim || (!neg && mag == lim))
        begin
            r.sat = 1'b1;
            r.val = neg ? {1'b1, {(COMP_WIDTH-1){1'b0}}} : {1'b0, {(COMP_WIDTH-1){1'b1}}};
        end
        else
        begin
            r.sat = 1'b0;
            r.val = neg ? (~mag[COMP_WIDTH-1:0] + 1'b1) : mag[COMP_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/vgu_sqrt_step.sv
// ----------------------------------------------------------------------------
// vgu_sqrt_step: one registered step of the restoring square root
// retires one root bit per stage from two radicand bits
// ----------------------------------------------------------------------------
module vgu_sqrt_step (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [vgu_pkg::SUM_W-1:0]    rad,
    input  logic [vgu_pkg::REM_W-1:0]    rem,
    input  logic [vgu_pkg::ROOT_W-1:0]   root,
    output logic [vgu_pkg::SUM_W-1:0]    rad_stg,
    output logic [vgu_pkg::REM_W-1:0]    rem_stg,
    output logic [vgu_pkg::ROOT_W-1:0]   root_stg
);

    logic [vgu_pkg::SUM_W-1:0]  rad_reg, rad_next;
    logic [vgu_pkg::REM_W-1:0]  rem_reg, rem_next, rem_sh, trial;
    logic [vgu_pkg::ROOT_W-1:0] root_reg, root_next;
    logic                       ge;

    always_comb
    begin
        rem_sh    = {rem[vgu_pkg::REM_W-3:0], rad[vgu_pkg::SUM_W-1 -: 2]};
        trial     = vgu_pkg::REM_W'({root, 2'b01});
        ge        = rem_sh >= trial;
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root[vgu_pkg::ROOT_W-2:0], ge};
        rad_next  = {rad[vgu_pkg::SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_stg  = rad_reg;
    assign rem_stg  = rem_reg;
    assign root_stg = root_reg;

endmodule

FILE: sv/vgu_div_step.sv
// ----------------------------------------------------------------------------
// vgu_div_step: one registered step of the restoring divider
// retires one quotient bit per stage
// ----------------------------------------------------------------------------
module vgu_div_step (
    input  logic                            clk,
    input  logic                            adv,
    input  logic [vgu_pkg::COMP_WIDTH-1:0]  den,
    input  logic [vgu_pkg::COMP_WIDTH-1:0]  rem,
    input  logic [vgu_pkg::QUO_W-1:0]       nlow,
    input  logic [vgu_pkg::QUO_W-1:0]       quo,
    output logic [vgu_pkg::COMP_WIDTH-1:0]  rem_stg,
    output logic [vgu_pkg::QUO_W-1:0]       nlow_stg,
    output logic [vgu_pkg::QUO_W-1:0]       quo_stg
);

    logic [vgu_pkg::COMP_WIDTH:0]   rem_sh, diff;
    logic [vgu_pkg::COMP_WIDTH-1:0] rem_reg, rem_next;
    logic [vgu_pkg::QUO_W-1:0]      nlow_reg, nlow_next, quo_reg, quo_next;
    logic                           ge;

    always_comb
    begin
        rem_sh    = {rem, nlow[vgu_pkg::QUO_W-1]};
        diff      = rem_sh - {1'b0, den};
        ge        = rem_sh >= {1'b0, den};
        rem_next  = ge ? diff[vgu_pkg::COMP_WIDTH-1:0] : rem_sh[vgu_pkg::COMP_WIDTH-1:0];
        nlow_next = {nlow[vgu_pkg::QUO_W-2:0], 1'b0};
        quo_next  = {quo[vgu_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            nlow_reg <= nlow_next;
            quo_reg  <= quo_next;
        end
    end

    assign rem_stg  = rem_reg;
    assign nlow_stg = nlow_reg;
    assign quo_stg  = quo_reg;

endmodule

FILE: sv/vector3_geometry_unit.sv
// ----------------------------------------------------------------------------
// vector3_geometry_unit: pipelined Q16.16 3d vector unit
// dot, cross, length, distance and normalize on two 3-component vectors
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries op and vectors a and b, output
//   channel out_valid/out_ready carries rx, ry, rz, scalar_out and status.
//   one item can be accepted every cycle; every op takes the same path.
//   path: an accepted item passes the input register, operand select,
//   multiply, sum, 34 square root stages one root bit each, 17 divider
//   stages one quotient bit each, and the output register.
//   throughput: one item per cycle while the receiver keeps up.
//   when out_ready is low the finished item waits in the output register and
//   the next one lands in a skid register; only then does the pipeline freeze
//   and in_ready drop. nothing is lost or repeated across a stall.
//   reset clears every valid bit; the first item may follow the reset release.
//   status 1 marks a saturated output, status 2 a zero vector in normalize.
// ----------------------------------------------------------------------------
module vector3_geometry_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [vgu_pkg::OP_W-1:0]              op,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] ax,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] ay,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] az,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] bx,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] by_comp,
    input  logic signed [vgu_pkg::COMP_WIDTH-1:0] bz,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vgu_pkg::COMP_WIDTH-1:0] rx,
    output logic signed [vgu_pkg::COMP_WIDTH-1:0] ry,
    output logic signed [vgu_pkg::COMP_WIDTH-1:0] rz,
    output logic signed [vgu_pkg::COMP_WIDTH-1:0] scalar_out,
    output logic [vgu_pkg::ST_W-1:0]              status
);

    logic adv;

    // input register
    logic                                  p1_valid_reg;
    logic [vgu_pkg::OP_W-1:0]              p1_op_reg;
    logic signed [vgu_pkg::COMP_WIDTH-1:0] p1_a_reg [3];
    logic signed [vgu_pkg::COMP_WIDTH-1:0] p1_b_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (adv)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_op_reg   <= op;
            p1_a_reg[0] <= ax;
            p1_a_reg[1] <= ay;
            p1_a_reg[2] <= az;
            p1_b_reg[0] <= bx;
            p1_b_reg[1] <= by_comp;
            p1_b_reg[2] <= bz;
        end
    end

    // operand select for the six shared multipliers
    logic signed [vgu_pkg::OPD_W-1:0]  ae [3];
    logic signed [vgu_pkg::OPD_W-1:0]  be [3];
    logic signed [vgu_pkg::OPD_W-1:0]  de [3];
    logic signed [vgu_pkg::OPD_W-1:0]  opa_next [6];
    logic signed [vgu_pkg::OPD_W-1:0]  opb_next [6];
    logic [vgu_pkg::COMP_WIDTH-1:0]    amag_next [3];
    logic [2:0]                        aneg_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ae[i] = vgu_pkg::OPD_W'(p1_a_reg[i]);
            be[i] = vgu_pkg::OPD_W'(p1_b_reg[i]);
            de[i] = ae[i] - be[i];
            aneg_next[i] = p1_a_reg[i][vgu_pkg::COMP_WIDTH-1];
            amag_next[i] = aneg_next[i] ? (~p1_a_reg[i] + 1'b1) : p1_a_reg[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            opa_next[i] = '0;
            opb_next[i] = '0;
        end
        unique case (p1_op_reg)
            vgu_pkg::OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa_next[i] = ae[i];
                    opb_next[i] = be[i];
                end
            end
            vgu_pkg::OP_CROSS:
            begin
                opa_next[0] = ae[1];  opb_next[0] = be[2];
                opa_next[1] = ae[2];  opb_next[1] = be[1];
                opa_next[2] = ae[2];  opb_next[2] = be[0];
                opa_next[3] = ae[0];  opb_next[3] = be[2];
                opa_next[4] = ae[0];  opb_next[4] = be[1];
                opa_next[5] = ae[1];  opb_next[5] = be[0];
            end
            vgu_pkg::OP_LEN, vgu_pkg::OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa_next[i] = ae[i];
                    opb_next[i] = ae[i];
                end
            end
            vgu_pkg::OP_DIST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa_next[i] = de[i];
                    opb_next[i] = de[i];
                end
            end
            default:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    opa_next[i] = '0;
                    opb_next[i] = '0;
                end
            end
        endcase
    end

    logic                              p2_valid_reg;
    logic [vgu_pkg::OP_W-1:0]          p2_op_reg;
    logic signed [vgu_pkg::OPD_W-1:0]  p2_opa_reg [6];
    logic signed [vgu_pkg::OPD_W-1:0]  p2_opb_reg [6];
    logic [vgu_pkg::COMP_WIDTH-1:0]    p2_amag_reg [3];
    logic [2:0]                        p2_aneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (adv)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_op_reg   <= p1_op_reg;
            p2_opa_reg  <= opa_next;
            p2_opb_reg  <= opb_next;
            p2_amag_reg <= amag_next;
            p2_aneg_reg <= aneg_next;
        end
    end

    // multiply
    logic                              p3_valid_reg;
    logic [vgu_pkg::OP_W-1:0]          p3_op_reg;
    logic signed [vgu_pkg::PROD_W-1:0] p3_prod_reg [6];
    logic [vgu_pkg::COMP_WIDTH-1:0]    p3_amag_reg [3];
    logic [2:0]                        p3_aneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (adv)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_op_reg   <= p2_op_reg;
            p3_amag_reg <= p2_amag_reg;
            p3_aneg_reg <= p2_aneg_reg;
            for (int i = 0; i < 6; i++)
                p3_prod_reg[i] <= p2_opa_reg[i] * p2_opb_reg[i];
        end
    end

    // sums: t0 is the dot sum or the radicand, or cross x
    logic signed [vgu_pkg::SUM_W-1:0] pe [6];
    logic signed [vgu_pkg::SUM_W-1:0] t_next [3];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            pe[i] = vgu_pkg::SUM_W'(p3_prod_reg[i]);
        t_next[0] = (p3_op_reg == vgu_pkg::OP_CROSS) ? (pe[0] - pe[1])
                                                     : (pe[0] + pe[1] + pe[2]);
        t_next[1] = pe[2] - pe[3];
        t_next[2] = pe[4] - pe[5];
    end

    logic                             p4_valid_reg;
    logic [vgu_pkg::OP_W-1:0]         p4_op_reg;
    logic signed [vgu_pkg::SUM_W-1:0] p4_t_reg [3];
    logic [vgu_pkg::COMP_WIDTH-1:0]   p4_amag_reg [3];
    logic [2:0]                       p4_aneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (adv)
            p4_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_op_reg   <= p3_op_reg;
            p4_t_reg    <= t_next;
            p4_amag_reg <= p3_amag_reg;
            p4_aneg_reg <= p3_aneg_reg;
        end
    end

    // dot and cross finish here, beside the first root step
    vgu_pkg::side_t             sq_side0;
    logic [vgu_pkg::SUM_W-1:0]  tmag [3];
    vgu_pkg::packed_t           tpk [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tmag[i] = p4_t_reg[i][vgu_pkg::SUM_W-1] ? (~p4_t_reg[i] + 1'b1) : p4_t_reg[i];
            tpk[i]  = vgu_pkg::sat_pack(tmag[i] >> vgu_pkg::FRAC_BITS,
                                        p4_t_reg[i][vgu_pkg::SUM_W-1]);
        end
        sq_side0        = '0;
        sq_side0.valid  = p4_valid_reg;
        sq_side0.op     = p4_op_reg;
        sq_side0.aneg   = p4_aneg_reg;
        for (int i = 0; i < 3; i++)
            sq_side0.amag[i] = p4_amag_reg[i];
        if (p4_op_reg == vgu_pkg::OP_DOT)
        begin
            sq_side0.scalar = tpk[0].val;
            sq_side0.sat    = tpk[0].sat;
        end
        else if (p4_op_reg == vgu_pkg::OP_CROSS)
        begin
            for (int i = 0; i < 3; i++)
                sq_side0.vec[i] = tpk[i].val;
            sq_side0.sat = tpk[0].sat | tpk[1].sat | tpk[2].sat;
        end
    end

    // square root pipeline
    logic [vgu_pkg::SUM_W-1:0]  sq_rad  [0:vgu_pkg::ROOT_W];
    logic [vgu_pkg::REM_W-1:0]  sq_rem  [0:vgu_pkg::ROOT_W];
    logic [vgu_pkg::ROOT_W-1:0] sq_root [0:vgu_pkg::ROOT_W];
    vgu_pkg::side_t             sq_side_reg [1:vgu_pkg::ROOT_W];

    assign sq_rad[0]  = p4_t_reg[0];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < vgu_pkg::ROOT_W; k++)
    begin : g_sqrt
        vgu_sqrt_step u_step (
            .clk      (clk),
            .adv      (adv),
            .rad      (sq_rad[k]),
            .rem      (sq_rem[k]),
            .root     (sq_root[k]),
            .rad_stg  (sq_rad[k+1]),
            .rem_stg  (sq_rem[k+1]),
            .root_stg (sq_root[k+1])
        );

        if (k == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_side_reg[k+1] <= '0;
                else if (adv)
                    sq_side_reg[k+1] <= sq_side0;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_side_reg[k+1] <= '0;
                else if (adv)
                    sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // length and distance finish here, normalize sets up its divider
    vgu_pkg::side_t   dv_side0;
    vgu_pkg::packed_t lpk;

    always_comb
    begin
        lpk      = vgu_pkg::sat_pack(vgu_pkg::SUM_W'(sq_root[vgu_pkg::ROOT_W]), 1'b0);
        dv_side0 = sq_side_reg[vgu_pkg::ROOT_W];
        dv_side0.den  = sq_root[vgu_pkg::ROOT_W][vgu_pkg::COMP_WIDTH-1:0];
        dv_side0.zero = (sq_root[vgu_pkg::ROOT_W] == '0);
        if (sq_side_reg[vgu_pkg::ROOT_W].op == vgu_pkg::OP_LEN ||
            sq_side_reg[vgu_pkg::ROOT_W].op == vgu_pkg::OP_DIST)
        begin
            dv_side0.scalar = lpk.val;
            dv_side0.sat    = lpk.sat;
        end
    end

    // divider pipeline, one lane per component
    logic [vgu_pkg::COMP_WIDTH-1:0] dv_rem  [3][0:vgu_pkg::QUO_W];
    logic [vgu_pkg::QUO_W-1:0]      dv_nlow [3][0:vgu_pkg::QUO_W];
    logic [vgu_pkg::QUO_W-1:0]      dv_quo  [3][0:vgu_pkg::QUO_W];
    vgu_pkg::side_t                 dv_side_reg [1:vgu_pkg::QUO_W];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        // numerator is |a| shifted up by the fraction bits
        assign dv_rem[c][0]  = dv_side0.amag[c] >> 1;
        assign dv_nlow[c][0] = {dv_side0.amag[c][0], {(vgu_pkg::QUO_W-1){1'b0}}};
        assign dv_quo[c][0]  = '0;

        for (genvar k = 0; k < vgu_pkg::QUO_W; k++)
        begin : g_div
            logic [vgu_pkg::COMP_WIDTH-1:0] den;

            if (k == 0)
            begin : g_den0
                assign den = dv_side0.den;
            end
            else
            begin : g_denk
                assign den = dv_side_reg[k].den;
            end

            vgu_div_step u_step (
                .clk      (clk),
                .adv      (adv),
                .den      (den),
                .rem      (dv_rem[c][k]),
                .nlow     (dv_nlow[c][k]),
                .quo      (dv_quo[c][k]),
                .rem_stg  (dv_rem[c][k+1]),
                .nlow_stg (dv_nlow[c][k+1]),
                .quo_stg  (dv_quo[c][k+1])
            );
        end
    end

    for (genvar k = 0; k < vgu_pkg::QUO_W; k++)
    begin : g_dside
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_side_reg[k+1] <= '0;
                else if (adv)
                    dv_side_reg[k+1] <= dv_side0;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_side_reg[k+1] <= '0;
                else if (adv)
                    dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // final assembly
    vgu_pkg::side_t             last;
    vgu_pkg::packed_t           npk [3];
    logic [2:0][vgu_pkg::COMP_WIDTH-1:0] vec_res;
    logic                       sat_res;
    vgu_pkg::result_t           res;

    always_comb
    begin
        last    = dv_side_reg[vgu_pkg::QUO_W];
        for (int i = 0; i < 3; i++)
            npk[i] = vgu_pkg::sat_pack(vgu_pkg::SUM_W'(dv_quo[i][vgu_pkg::QUO_W]), last.aneg[i]);
        vec_res = last.vec;
        sat_res = last.sat;
        res     = '0;
        if (last.op == vgu_pkg::OP_NORM)
        begin
            if (last.zero)
            begin
                vec_res = '0;
                sat_res = 1'b0;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    vec_res[i] = npk[i].val;
                sat_res = npk[0].sat | npk[1].sat | npk[2].sat;
            end
        end
        res.rx     = vec_res[0];
        res.ry     = vec_res[1];
        res.rz     = vec_res[2];
        res.scalar = last.scalar;
        if (last.op == vgu_pkg::OP_NORM && last.zero)
            res.status = vgu_pkg::ST_ZERO;
        else if (sat_res)
            res.status = vgu_pkg::ST_SAT;
        else
            res.status = vgu_pkg::ST_OK;
    end

    // output register with skid slot
    logic             out_valid_reg, skid_valid_reg;
    vgu_pkg::result_t out_reg, skid_reg;
    logic             take;

    assign adv  = !skid_valid_reg;
    assign take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last.valid;
                out_reg       <= res;
            end
        end
        else if (last.valid && adv)
        begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= res;
        end
    end

    assign in_ready   = adv;
    assign out_valid  = out_valid_reg;
    assign rx         = out_reg.rx;
    assign ry         = out_reg.ry;
    assign rz         = out_reg.rz;
    assign scalar_out = out_reg.scalar;
    assign status     = out_reg.status;

endmodule

FILE: sv/vgu_checker.sv
// ----------------------------------------------------------------------------
// vgu_checker: port level checks for the 3d vector unit
// watches the result channel of the top level
// ----------------------------------------------------------------------------
module vgu_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [vgu_pkg::COMP_WIDTH-1:0] rx,
    input logic signed [vgu_pkg::COMP_WIDTH-1:0] ry,
    input logic signed [vgu_pkg::COMP_WIDTH-1:0] rz,
    input logic signed [vgu_pkg::COMP_WIDTH-1:0] scalar_out,
    input logic [vgu_pkg::ST_W-1:0]              status
);

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({rx, ry, rz, scalar_out, status}))
        else $error("stalled item changed");

    // a zero vector in normalize gives all zero fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == vgu_pkg::ST_ZERO |->
            rx == '0 && ry == '0 && rz == '0 && scalar_out == '0)
        else $error("zero vector item with nonzero field");

    // vector and scalar results never both appear
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx != '0 || ry != '0 || rz != '0) |-> scalar_out == '0)
        else $error("vector and scalar result together");

    // no item leaves while nothing could have entered since reset
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("item right after reset");

endmodule

bind vector3_geometry_unit vgu_checker u_vgu_checker (.*);
